// File: rtl/rfc_pkg.sv
package rfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxSeed = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxPoly = 1'b1;

  localparam logic [CrcW-1:0] CrcSeedRst = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPolyRst = 16'h8408;
  localparam logic [CrcW-1:0] CrcLsbMask = 16'h0001;

  // Shortest frame that carries a header and a CRC
  localparam logic [ByteW-1:0] MinFrameLen = 8'd5;

  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  localparam logic [1:0] CodeOk     = 2'd0;
  localparam logic [1:0] CodeShort  = 2'd1;
  localparam logic [1:0] CodeCrcErr = 2'd2;

  typedef struct packed {
    logic [CrcW-1:0] seed;
    logic [CrcW-1:0] poly;
  } rfc_cfg_t;

  typedef struct packed {
    logic             result_kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] reader_address;
    logic [ByteW-1:0] response_command;
    logic [ByteW-1:0] reader_status;
    logic [1:0]       frame_code;
  } rfc_result_t;

endpackage

// File: rtl/rfc_if.sv
interface rfc_byte_if;
  logic                     valid;
  logic                     ready;
  logic [rfc_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfc_result_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [rfc_pkg::ByteW-1:0] payload_byte;
  logic [rfc_pkg::ByteW-1:0] reader_address;
  logic [rfc_pkg::ByteW-1:0] response_command;
  logic [rfc_pkg::ByteW-1:0] reader_status;
  logic [1:0]                frame_code;

  modport source (
    output valid, output result_kind, output payload_byte, output reader_address,
    output response_command, output reader_status, output frame_code, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input reader_address,
    input response_command, input reader_status, input frame_code, output ready
  );
endinterface

// File: rtl/response_frame_checker_crc16.sv
// Response frame checker with reflected CRC-16.
//
// rx carries received serial bytes, one request per byte. The first byte of
// a frame is a count of the bytes that follow: address, command, status,
// payload, then CRC low and high. res carries one request per payload byte
// (result_kind 0) and one frame-end request on the last byte of each frame
// (result_kind 1) with frame_code ok, too short or CRC mismatch. Other bytes
// (length, header, CRC low, short-frame body) are absorbed silently.
// The cfg port writes the CRC seed (index 0) and polynomial (index 1); write
// only while no frame byte is in flight.
//
// Path: a byte taken on rx is held in the input register, and its result
// is offered on res from the result register, where it holds until res is
// ready. Throughput: one byte per cycle, set by the combinational
// byte-wide CRC fold and phase update, unless a result-bearing byte waits.
// Reset clears both registers' valid flags, the frame state and the
// configuration to seed 0xFFFF, polynomial 0x8408. When res stalls, the
// result register holds; the input register still drains bytes that give
// no result, and rx.ready drops only once a result-bearing byte waits.
module response_frame_checker_crc16 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rfc_byte_if.sink                      rx,
  rfc_result_if.source                  res,
  input  logic                          cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfc_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  rfc_pkg::rfc_cfg_t    cfg;
  rfc_pkg::rfc_result_t step_result;
  logic                 step_has_result;

  // Input register
  logic                      in_valid_q;
  logic [rfc_pkg::ByteW-1:0] in_byte_q;
  // Result register
  logic                      out_valid_q;
  rfc_pkg::rfc_result_t      out_q;

  logic in_fire, step_fire;

  // Advance the input register unless its byte needs a result slot that
  // is still taken
  assign step_fire = in_valid_q && (!out_valid_q || res.ready || !step_has_result);
  assign rx.ready  = !in_valid_q || step_fire;
  assign in_fire   = rx.valid && rx.ready;

  rfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rfc_frame_fsm u_frame_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step_fire),
    .byte_i       (in_byte_q),
    .cfg_i        (cfg),
    .has_result_o (step_has_result),
    .result_o     (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && step_has_result) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && step_has_result) begin
      out_q <= step_result;
    end
  end

  assign res.valid            = out_valid_q;
  assign res.result_kind      = out_q.result_kind;
  assign res.payload_byte     = out_q.payload_byte;
  assign res.reader_address   = out_q.reader_address;
  assign res.response_command = out_q.response_command;
  assign res.reader_status    = out_q.reader_status;
  assign res.frame_code       = out_q.frame_code;

endmodule

// File: rtl/rfc_cfg_regs.sv
module rfc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output rfc_pkg::rfc_cfg_t              cfg_o
);

  rfc_pkg::rfc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        rfc_pkg::CfgIdxSeed: cfg_d.seed = cfg_wdata_i[rfc_pkg::CrcW-1:0];
        rfc_pkg::CfgIdxPoly: cfg_d.poly = cfg_wdata_i[rfc_pkg::CrcW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed <= rfc_pkg::CrcSeedRst;
      cfg_q.poly <= rfc_pkg::CrcPolyRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/rfc_crc8.sv
module rfc_crc8 (
  input  logic [rfc_pkg::CrcW-1:0]  crc_i,
  input  logic [rfc_pkg::ByteW-1:0] data_i,
  input  logic [rfc_pkg::CrcW-1:0]  poly_i,
  output logic [rfc_pkg::CrcW-1:0]  crc_o
);

  logic [rfc_pkg::CrcW-1:0] c;

  // Fold one byte, LSB first, as eight shift steps
  always_comb begin
    c = crc_i ^ {{(rfc_pkg::CrcW-rfc_pkg::ByteW){1'b0}}, data_i};
    for (int k = 0; k < rfc_pkg::ByteW; k++) begin
      if ((c & rfc_pkg::CrcLsbMask) != '0) begin
        c = (c >> 1) ^ poly_i;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// File: rtl/rfc_frame_fsm.sv
module rfc_frame_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [rfc_pkg::ByteW-1:0]   byte_i,
  input  rfc_pkg::rfc_cfg_t           cfg_i,
  output logic                        has_result_o,
  output rfc_pkg::rfc_result_t        result_o
);

  localparam logic [2:0] PhLen  = 3'd0;
  localparam logic [2:0] PhAddr = 3'd1;
  localparam logic [2:0] PhCmd  = 3'd2;
  localparam logic [2:0] PhStat = 3'd3;
  localparam logic [2:0] PhData = 3'd4;
  localparam logic [2:0] PhCrcl = 3'd5;
  localparam logic [2:0] PhCrch = 3'd6;
  localparam logic [2:0] PhSkip = 3'd7;

  logic [2:0]                phase_q, phase_d;
  logic [rfc_pkg::ByteW-1:0] remain_q, remain_d;
  logic [rfc_pkg::CrcW-1:0]  crc_q, crc_d;
  logic [rfc_pkg::ByteW-1:0] addr_q, addr_d;
  logic [rfc_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic [rfc_pkg::ByteW-1:0] stat_q, stat_d;
  logic [rfc_pkg::ByteW-1:0] crcl_q, crcl_d;

  logic [rfc_pkg::CrcW-1:0]  crc_in, crc_fold;
  logic [rfc_pkg::ByteW-1:0] remain_dec;
  logic [rfc_pkg::ByteW-1:0] body_byte;

  assign crc_in     = (phase_q == PhLen) ? cfg_i.seed : crc_q;
  assign remain_dec = remain_q - 8'd1;

  rfc_crc8 u_crc8 (
    .crc_i  (crc_in),
    .data_i (byte_i),
    .poly_i (cfg_i.poly),
    .crc_o  (crc_fold)
  );

  always_comb begin
    phase_d      = phase_q;
    remain_d     = remain_q;
    crc_d        = crc_q;
    addr_d       = addr_q;
    cmd_d        = cmd_q;
    stat_d       = stat_q;
    crcl_d       = crcl_q;
    has_result_o = 1'b0;
    body_byte    = '0;
    result_o.result_kind = rfc_pkg::KindFrameEnd;
    result_o.frame_code  = rfc_pkg::CodeOk;

    case (phase_q)
      PhLen: begin
        addr_d   = '0;
        cmd_d    = '0;
        stat_d   = '0;
        crcl_d   = '0;
        remain_d = byte_i;
        crc_d    = crc_fold;
        if (byte_i == '0) begin
          phase_d             = PhLen;
          has_result_o        = 1'b1;
          result_o.frame_code = rfc_pkg::CodeShort;
        end else if (byte_i < rfc_pkg::MinFrameLen) begin
          phase_d = PhSkip;
        end else begin
          phase_d = PhAddr;
        end
      end
      PhSkip: begin
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          phase_d             = PhLen;
          has_result_o        = 1'b1;
          result_o.frame_code = rfc_pkg::CodeShort;
        end
      end
      PhAddr: begin
        addr_d   = byte_i;
        crc_d    = crc_fold;
        remain_d = remain_dec;
        phase_d  = PhCmd;
      end
      PhCmd: begin
        cmd_d    = byte_i;
        crc_d    = crc_fold;
        remain_d = remain_dec;
        phase_d  = PhStat;
      end
      PhStat: begin
        stat_d   = byte_i;
        crc_d    = crc_fold;
        remain_d = remain_dec;
        phase_d  = (remain_dec == 8'd2) ? PhCrcl : PhData;
      end
      PhData: begin
        crc_d        = crc_fold;
        remain_d     = remain_dec;
        phase_d      = (remain_dec == 8'd2) ? PhCrcl : PhData;
        has_result_o = 1'b1;
        body_byte    = byte_i;
        result_o.result_kind = rfc_pkg::KindPayload;
      end
      PhCrcl: begin
        crcl_d   = byte_i;
        remain_d = remain_dec;
        phase_d  = PhCrch;
      end
      default: begin
        // CRC high byte closes the frame
        remain_d     = '0;
        phase_d      = PhLen;
        has_result_o = 1'b1;
        result_o.frame_code = ({byte_i, crcl_q} == crc_q) ? rfc_pkg::CodeOk
                                                          : rfc_pkg::CodeCrcErr;
      end
    endcase

    result_o.payload_byte     = body_byte;
    result_o.reader_address   = addr_d;
    result_o.response_command = cmd_d;
    result_o.reader_status    = stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLen;
      remain_q <= '0;
      crc_q    <= rfc_pkg::CrcSeedRst;
      addr_q   <= '0;
      cmd_q    <= '0;
      stat_q   <= '0;
      crcl_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      crc_q    <= crc_d;
      addr_q   <= addr_d;
      cmd_q    <= cmd_d;
      stat_q   <= stat_d;
      crcl_q   <= crcl_d;
    end
  end

endmodule

// File: rtl/rfc_checker.sv
module rfc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      result_kind_i,
  input logic [rfc_pkg::ByteW-1:0] payload_byte_i,
  input logic [1:0]                frame_code_i
);

  // A stalled request holds its kind, payload byte and frame code
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i)
      && $stable(payload_byte_i) && $stable(frame_code_i))
    else $error("result changed while stalled");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> frame_code_i != 2'd3)
    else $error("undefined frame code");

  a_payload_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == rfc_pkg::KindPayload
      |-> frame_code_i == rfc_pkg::CodeOk)
    else $error("payload result with frame code");

  a_end_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == rfc_pkg::KindFrameEnd |-> payload_byte_i == '0)
    else $error("frame-end result with payload data");

endmodule

bind response_frame_checker_crc16 rfc_checker u_rfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res.valid),
  .out_ready_i    (res.ready),
  .result_kind_i  (res.result_kind),
  .payload_byte_i (res.payload_byte),
  .frame_code_i   (res.frame_code)
);
